// ===== hdl/mmcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmcc_pkg: shared types and codes for the multi-click classifier
// Tick and result payloads, configuration bundle, action and register codes.
// ----------------------------------------------------------------------------
package mmcc_pkg;

	localparam int PTR_W     = 14;
	localparam int TIMEOUT_W = 12;
	localparam int TOL_W     = 8;
	localparam int LIMIT_W   = 5;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SINGLE     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DOUBLE     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TRIPLE     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DRAG_START = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DRAG       = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

	// reset values
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 12'd450;
	localparam logic [TOL_W-1:0]     TOL_RST     = 8'd10;
	localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 5'd16;
	localparam logic [LIMIT_W-1:0]   DRAG_MAX    = 5'd31;
	localparam logic [LIMIT_W-1:0]   DRAG_ONE    = 5'd1;

	typedef struct packed {
		logic             press_event;
		logic             release_event;
		logic             slide_start;
		logic [PTR_W-1:0] pointer_x;
		logic [PTR_W-1:0] pointer_y;
	} tick_t;

	typedef struct packed {
		logic [ACT_W-1:0] action_code;
		logic             notify_pulse;
		logic             destroy_icon;
		logic             clear_selection;
		logic             button_down;
	} result_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [TOL_W-1:0]     move_tolerance;
		logic [LIMIT_W-1:0]   slide_tick_limit;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hdl/mmcc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmcc_cfg: configuration registers
// Holds timeout, movement tolerance and drag tick limit; writes by index.
// ----------------------------------------------------------------------------
module mmcc_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [mmcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [mmcc_pkg::CFG_DAT_W-1:0]  wr_data,
	output mmcc_pkg::cfg_t                       cfg
);
	import mmcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks    <= TIMEOUT_RST;
			cfg_q.move_tolerance   <= TOL_RST;
			cfg_q.slide_tick_limit <= LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TIMEOUT:   cfg_q.timeout_ticks    <= wr_data[TIMEOUT_W-1:0];
				CFG_TOLERANCE: cfg_q.move_tolerance   <= wr_data[TOL_W-1:0];
				CFG_LIMIT:     cfg_q.slide_tick_limit <= wr_data[LIMIT_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/mmcc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmcc_core: gesture state and per-tick classification
// Holds the click state and computes one result per tick in a single pass.
// ----------------------------------------------------------------------------
module mmcc_core #(
	parameter int COORD_BITS = 14,
	parameter int TIMER_BITS = 12
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mmcc_pkg::cfg_t  cfg,
	input  wire logic    step_en,
	input  wire mmcc_pkg::tick_t tick,
	output mmcc_pkg::result_t result
);
	import mmcc_pkg::*;

	localparam int PW = (COORD_BITS > PTR_W) ? COORD_BITS : PTR_W;
	localparam int TW = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic [ACT_W-1:0]      act_q, act_n;
	logic                  drag_q, drag_n;
	logic [LIMIT_W-1:0]    dticks_q, dticks_n;
	logic [TIMER_BITS-1:0] idle_q, idle_n;
	logic                  armed_q, armed_n;
	logic [COORD_BITS-1:0] last_x_q, last_x_n;
	logic [COORD_BITS-1:0] last_y_q, last_y_n;
	logic                  btn_q, btn_n;
	logic                  req, notify, destroy, clr;
	logic [PW-1:0]         px_w, py_w;
	logic [COORD_BITS-1:0] px, py, dx, dy, tol;

	assign px_w = PW'(tick.pointer_x);
	assign py_w = PW'(tick.pointer_y);
	assign px   = px_w[COORD_BITS-1:0];
	assign py   = py_w[COORD_BITS-1:0];
	assign dx   = (px > last_x_q) ? (px - last_x_q) : (last_x_q - px);
	assign dy   = (py > last_y_q) ? (py - last_y_q) : (last_y_q - py);
	assign tol  = COORD_BITS'(cfg.move_tolerance);

	always_comb begin
		act_n    = act_q;
		drag_n   = drag_q | tick.slide_start;
		dticks_n = dticks_q;
		idle_n   = idle_q;
		armed_n  = armed_q;
		last_x_n = last_x_q;
		last_y_n = last_y_q;
		btn_n    = btn_q;
		req      = 1'b0;
		notify   = 1'b0;
		destroy  = 1'b0;
		clr      = 1'b0;

		// idle timeout
		if (armed_q) begin
			if (idle_q < TIMER_MAX)
				idle_n = idle_q + 1'b1;
			if (TW'(idle_n) > TW'(cfg.timeout_ticks)) begin
				if (!drag_n)
					act_n = ACT_NONE;
				armed_n = 1'b0;
			end
		end

		if (tick.press_event) begin
			btn_n = 1'b1;
			req   = 1'b1;
		end

		// drag tick
		if (drag_n) begin
			if (dticks_n < DRAG_MAX)
				dticks_n = dticks_n + 1'b1;
			act_n = ACT_DRAG_START;
			req   = 1'b0;
		end

		if (tick.release_event) begin
			btn_n = 1'b0;
			if (act_n != ACT_DOUBLE)
				req = 1'b0;
			if (act_n == ACT_DRAG_START) begin
				req    = 1'b1;
				drag_n = 1'b0;
			end
		end

		if (req) begin
			case (act_n)
				ACT_TRIPLE, ACT_DRAG, ACT_NONE: begin
					act_n = ACT_SINGLE;
					clr   = 1'b1;
					if (dticks_n > cfg.slide_tick_limit || dticks_n == DRAG_ONE) begin
						destroy = 1'b1;
					end else begin
						// short drag merges into a double click
						act_n  = ACT_DOUBLE;
						notify = 1'b1;
					end
					dticks_n = DRAG_ONE;
				end
				ACT_SINGLE: begin
					act_n    = ACT_DOUBLE;
					last_x_n = px;
					last_y_n = py;
					notify   = 1'b1;
				end
				ACT_DOUBLE: begin
					if (dx > tol || dy > tol) begin
						act_n   = ACT_SINGLE;
						destroy = 1'b1;
					end else begin
						act_n  = ACT_TRIPLE;
						notify = 1'b1;
					end
				end
				ACT_DRAG_START: begin
					act_n  = ACT_DRAG;
					notify = 1'b1;
				end
				default: begin
					// unused codes hold
				end
			endcase
			idle_n  = '0;
			armed_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= ACT_NONE;
			drag_q   <= 1'b0;
			dticks_q <= DRAG_ONE;
			idle_q   <= TIMER_MAX;
			armed_q  <= 1'b1;
			last_x_q <= '0;
			last_y_q <= '0;
			btn_q    <= 1'b0;
		end else if (step_en) begin
			act_q    <= act_n;
			drag_q   <= drag_n;
			dticks_q <= dticks_n;
			idle_q   <= idle_n;
			armed_q  <= armed_n;
			last_x_q <= last_x_n;
			last_y_q <= last_y_n;
			btn_q    <= btn_n;
		end
	end

	assign result.action_code     = act_n;
	assign result.notify_pulse    = notify;
	assign result.destroy_icon    = destroy;
	assign result.clear_selection = clr;
	assign result.button_down     = btn_n;

endmodule
`default_nettype wire

// ===== hdl/mouse_multi_click_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_multi_click_classifier: tick-driven multi-click detector
// Sorts button activity into single, double, triple click, drag start and drag.
// ----------------------------------------------------------------------------
// Path: a tick passes the input register, then the result register, and
// waits in the input register while the result side stalls.
// Throughput: one tick per cycle unless the result side stalls; the gesture
// state updates once per tick.
// Reset: arst_n clears the handshake stages, loads the configuration
// defaults and puts the gesture state in its no-action condition.
module mouse_multi_click_classifier #(
	parameter int COORD_BITS = 14,
	parameter int TIMER_BITS = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// tick channel
	input  wire logic                           tick_valid,
	output logic                                tick_stall,
	input  wire mmcc_pkg::tick_t                tick,
	// result channel
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output mmcc_pkg::result_t                   result,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mmcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mmcc_pkg::CFG_DAT_W-1:0] cfg_data
);
	import mmcc_pkg::*;

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    tick_valid_s1;
	result_t step_result;
	result_t result_s2;
	logic    result_valid_s2;
	logic    advance;
	logic    tick_take;

	// always ready: configuration writes never wait
	assign cfg_ready = 1'b1;

	mmcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the held tick whenever the result register is free or draining
	assign advance    = tick_valid_s1 && (!result_valid_s2 || !result_stall);
	assign tick_stall = tick_valid_s1 && !advance;
	assign tick_take  = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (advance || !tick_valid_s1) begin
			tick_valid_s1 <= tick_take;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (tick_take)
			tick_s1 <= tick;
	end

	// classification happens as the tick moves into the result register
	mmcc_core #(
		.COORD_BITS (COORD_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (advance),
		.tick    (tick_s1),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			// drop valid once the result transfer completes
			result_valid_s2 <= 1'b0;
		end
	end

	// hold the result while stalled
	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= step_result;
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

endmodule
`default_nettype wire

// ===== test/tb_mouse_multi_click_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mouse_multi_click_classifier: self-checking bench for the click classifier
// Streams tick items through the block under random idling on both
// channels. A gesture tracker mirrors the classification rules and checks
// every result in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_mouse_multi_click_classifier;
	import mmcc_pkg::*;

	localparam logic [PTR_W-1:0] PTR_MAX = '1;

	// Tracks the gesture state one tick at a time and keeps the reports
	// the block owes us, oldest first.
	class gesture_tracker;
		logic [TIMEOUT_W-1:0] timeout;
		logic [TOL_W-1:0]     tolerance;
		logic [LIMIT_W-1:0]   limit;
		logic [ACT_W-1:0]     action;
		logic                 dragging;
		logic [LIMIT_W-1:0]   drag_count;
		logic [TIMEOUT_W-1:0] idle_count;
		logic                 timer_on;
		logic [PTR_W-1:0]     anchor_x;
		logic [PTR_W-1:0]     anchor_y;
		logic                 held;
		result_t              expected_reports[$];
		int                   mismatches;
		int                   ticks_seen;
		int                   action_hist[8];

		function new();
			timeout    = TIMEOUT_RST;
			tolerance  = TOL_RST;
			limit      = LIMIT_RST;
			action     = ACT_NONE;
			dragging   = 1'b0;
			drag_count = DRAG_ONE;
			idle_count = '1;
			timer_on   = 1'b1;
			anchor_x   = '0;
			anchor_y   = '0;
			held       = 1'b0;
			mismatches = 0;
			ticks_seen = 0;
			foreach (action_hist[i]) action_hist[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				CFG_TIMEOUT:   timeout   = val[TIMEOUT_W-1:0];
				CFG_TOLERANCE: tolerance = val[TOL_W-1:0];
				CFG_LIMIT:     limit     = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// Apply one accepted tick and queue the report it must produce.
		function void note_tick(tick_t t);
			logic             classify;
			logic [PTR_W-1:0] dx;
			logic [PTR_W-1:0] dy;
			result_t          want;
			want     = '0;
			classify = 1'b0;
			ticks_seen++;
			if (t.slide_start)
				dragging = 1'b1;
			// idle timer: saturate, then drop back to no action unless dragging
			if (timer_on) begin
				if (idle_count != '1)
					idle_count++;
				if (idle_count > timeout) begin
					if (!dragging)
						action = ACT_NONE;
					timer_on = 1'b0;
				end
			end
			if (t.press_event) begin
				held     = 1'b1;
				classify = 1'b1;
			end
			// a drag tick swallows any press in the same tick
			if (dragging) begin
				if (drag_count != DRAG_MAX)
					drag_count++;
				action   = ACT_DRAG_START;
				classify = 1'b0;
			end
			if (t.release_event) begin
				held = 1'b0;
				if (action != ACT_DOUBLE)
					classify = 1'b0;
				if (action == ACT_DRAG_START) begin
					classify = 1'b1;
					dragging = 1'b0;
				end
			end
			if (classify) begin
				case (action)
					ACT_TRIPLE, ACT_DRAG, ACT_NONE: begin
						action               = ACT_SINGLE;
						want.clear_selection = 1'b1;
						if (drag_count > limit || drag_count == DRAG_ONE) begin
							want.destroy_icon = 1'b1;
						end else begin
							// short drag between clicks merges into a double
							action            = ACT_DOUBLE;
							want.notify_pulse = 1'b1;
						end
						drag_count = DRAG_ONE;
					end
					ACT_SINGLE: begin
						action            = ACT_DOUBLE;
						anchor_x          = t.pointer_x;
						anchor_y          = t.pointer_y;
						want.notify_pulse = 1'b1;
					end
					ACT_DOUBLE: begin
						dx = (t.pointer_x > anchor_x) ? t.pointer_x - anchor_x
							: anchor_x - t.pointer_x;
						dy = (t.pointer_y > anchor_y) ? t.pointer_y - anchor_y
							: anchor_y - t.pointer_y;
						if (dx > tolerance || dy > tolerance) begin
							action            = ACT_SINGLE;
							want.destroy_icon = 1'b1;
						end else begin
							action            = ACT_TRIPLE;
							want.notify_pulse = 1'b1;
						end
					end
					ACT_DRAG_START: begin
						action            = ACT_DRAG;
						want.notify_pulse = 1'b1;
					end
					default: ;
				endcase
				idle_count = '0;
				timer_on   = 1'b1;
			end
			want.action_code = action;
			want.button_down = held;
			expected_reports.push_back(want);
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result act=%0d with no tick waiting", $time,
						got.action_code);
				return;
			end
			want = expected_reports.pop_front();
			action_hist[want.action_code]++;
			if (got.action_code !== want.action_code ||
				got.notify_pulse !== want.notify_pulse ||
				got.destroy_icon !== want.destroy_icon ||
				got.clear_selection !== want.clear_selection ||
				got.button_down !== want.button_down) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: want act=%0d ntf=%b dst=%b clr=%b btn=%b, got act=%0d ntf=%b dst=%b clr=%b btn=%b",
						$time, want.action_code, want.notify_pulse,
						want.destroy_icon, want.clear_selection, want.button_down,
						got.action_code, got.notify_pulse, got.destroy_icon,
						got.clear_selection, got.button_down);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_stall;
	tick_t                tick = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TIMEOUT;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	gesture_tracker tracker;
	tick_t          stim_q[$];
	bit             quiet = 1'b0;
	int             stall_left = 0;
	bit             stall_now = 1'b0;
	int             settings_used = 1;

	mouse_multi_click_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Sample both channels at the edge: note the tick before checking the
	// result so a same-edge pair always sees the expectation first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				tracker.note_tick(tick);
			if (result_valid && !result_stall)
				tracker.check_report(result);
		end
	end

	// Receiver back-pressure: alternate stall and run bursts; hold off
	// entirely during quiet phases.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_now  = !quiet && ($urandom_range(0, 2) == 0);
			stall_left = stall_now ? pause_len() : $urandom_range(1, 6);
		end
		stall_left--;
		result_stall <= stall_now;
	end

	task automatic put(input bit p, input bit r, input bit s,
		input logic [PTR_W-1:0] x, input logic [PTR_W-1:0] y);
		tick_t t;
		t.press_event   = p;
		t.release_event = r;
		t.slide_start   = s;
		t.pointer_x     = x;
		t.pointer_y     = y;
		stim_q.push_back(t);
	endtask

	task automatic add_idle(input int n, input logic [PTR_W-1:0] x,
		input logic [PTR_W-1:0] y);
		repeat (n) put(1'b0, 1'b0, 1'b0, x, y);
	endtask

	// Move a coordinate by up to span pixels either way; wrap at the edges.
	function automatic logic [PTR_W-1:0] nudge(logic [PTR_W-1:0] c, int span);
		logic [PTR_W-1:0] d;
		d = PTR_W'($urandom_range(0, 2 * span) - span);
		return c + d;
	endfunction

	// Fill the stimulus queue with gestures until it holds at least count ticks.
	// Most are well-formed clicks and drags with random content; the rest
	// are timeouts and raw noise.
	task automatic add_random(input int count);
		int               kind;
		int               clicks;
		int               len;
		int               tol;
		logic [PTR_W-1:0] x;
		logic [PTR_W-1:0] y;
		while (stim_q.size() < count) begin
			kind = $urandom_range(0, 99);
			tol  = int'(tracker.tolerance);
			x    = PTR_W'($urandom);
			y    = PTR_W'($urandom);
			if (kind < 20) begin
				// single click with a short hold
				put(1'b1, 1'b0, 1'b0, x, y);
				add_idle($urandom_range(0, 3), x, y);
				put(1'b0, 1'b1, 1'b0, x, y);
				add_idle($urandom_range(0, 4), x, y);
			end else if (kind < 45) begin
				// double or triple; the last click of a triple may wander past tolerance
				clicks = $urandom_range(2, 3);
				for (int c = 0; c < clicks; c++) begin
					if (c == clicks - 1 && clicks == 3) begin
						x = nudge(x, tol + $urandom_range(0, 3));
						y = nudge(y, tol + $urandom_range(0, 3));
					end
					put(1'b1, 1'b0, 1'b0, x, y);
					add_idle($urandom_range(0, 1), x, y);
					put(1'b0, 1'b1, 1'b0, x, y);
					add_idle($urandom_range(0, 3), x, y);
				end
			end else if (kind < 65) begin
				// drag, short or long enough to saturate the drag counter
				put(1'b1, 1'b0, 1'b0, x, y);
				add_idle($urandom_range(0, 1), x, y);
				put(1'b0, 1'b0, 1'b1, x, y);
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 36)
					: $urandom_range(0, tracker.limit + 2);
				repeat (len) begin
					x = nudge(x, 4);
					put(1'b0, 1'b0, 1'b0, x, y);
				end
				put(1'b0, 1'b1, 1'b0, x, y);
				// follow with a click to try the merge into a double
				if ($urandom_range(0, 1) == 1) begin
					put(1'b1, 1'b0, 1'b0, x, y);
					put(1'b0, 1'b1, 1'b0, x, y);
				end
			end else if (kind < 75) begin
				// sit idle, around the timeout boundary when the timeout is short
				len = (tracker.timeout < 64) ? tracker.timeout + $urandom_range(0, 3)
					: $urandom_range(1, 20);
				add_idle(len, x, y);
			end else begin
				repeat ($urandom_range(1, 3))
					put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), PTR_W'($urandom), PTR_W'($urandom));
			end
		end
	endtask

	// Send the queued ticks with random gaps, then drain every result.
	task automatic run_ticks();
		int gap;
		while (stim_q.size() > 0) begin
			gap = (quiet || $urandom_range(0, 1) == 1) ? 0 : pause_len();
			if (gap > 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tick       <= stim_q.pop_front();
			tick_valid <= 1'b1;
			do @(posedge clk); while (tick_stall);
		end
		tick_valid <= 1'b0;
		// advance one edge so the last transfer is noted before draining
		@(posedge clk);
		while (tracker.expected_reports.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers back to back; drop valid only at the end.
	task automatic configure(input logic [TIMEOUT_W-1:0] to,
		input logic [TOL_W-1:0] tol, input logic [LIMIT_W-1:0] lim);
		logic [CFG_IDX_W-1:0] idx[3];
		logic [CFG_DAT_W-1:0] val[3];
		idx[0] = CFG_TIMEOUT;
		idx[1] = CFG_TOLERANCE;
		idx[2] = CFG_LIMIT;
		val[0] = CFG_DAT_W'(to);
		val[1] = CFG_DAT_W'(tol);
		val[2] = CFG_DAT_W'(lim);
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			tracker.set_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset defaults. The first tick lets the
		// saturated timer expire.
		put(1'b0, 1'b0, 1'b0, '0, '0);
		// single, double, triple at the far corner
		put(1'b1, 1'b0, 1'b0, PTR_MAX, PTR_MAX);
		put(1'b0, 1'b1, 1'b0, PTR_MAX, PTR_MAX);
		put(1'b1, 1'b0, 1'b0, PTR_MAX, PTR_MAX);
		put(1'b0, 1'b1, 1'b0, PTR_MAX, PTR_MAX);
		put(1'b1, 1'b0, 1'b0, PTR_MAX - 10, PTR_MAX);
		put(1'b0, 1'b1, 1'b0, PTR_MAX - 10, PTR_MAX);
		// a click after a triple restarts as a single
		put(1'b1, 1'b0, 1'b0, PTR_MAX, PTR_MAX);
		put(1'b0, 1'b1, 1'b0, PTR_MAX, PTR_MAX);
		// double at the origin, then a third click one pixel too far
		put(1'b1, 1'b0, 1'b0, '0, '0);
		put(1'b0, 1'b1, 1'b0, '0, '0);
		put(1'b1, 1'b0, 1'b0, 14'd11, '0);
		put(1'b0, 1'b1, 1'b0, 14'd11, '0);
		// short drag, then a click merges into a double
		put(1'b1, 1'b0, 1'b0, 14'd100, 14'd100);
		put(1'b0, 1'b0, 1'b1, 14'd101, 14'd100);
		add_idle(3, 14'd102, 14'd100);
		put(1'b0, 1'b1, 1'b0, 14'd102, 14'd100);
		put(1'b1, 1'b0, 1'b0, 14'd102, 14'd100);
		put(1'b0, 1'b1, 1'b0, 14'd102, 14'd100);
		// the merged double kept the old anchor; this click is within tolerance of it
		put(1'b1, 1'b0, 1'b0, 14'd102, 14'd100);
		put(1'b0, 1'b1, 1'b0, 14'd102, 14'd100);
		// every event in one tick
		put(1'b1, 1'b1, 1'b1, PTR_MAX, '0);

		// Random gestures, then a stretch long enough for the default timeout.
		add_random(300);
		add_idle(455, '0, PTR_MAX);
		add_random(790);
		run_ticks();

		// Further phases: all-zero extremes (limit of zero included), a
		// timer that never expires with no idling, then random settings.
		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: configure('0, '0, '0);
				2: configure('1, '1, 5'd30);
				default: configure(TIMEOUT_W'($urandom_range(3, 40)),
					TOL_W'($urandom_range(0, 24)), LIMIT_W'($urandom_range(1, 30)));
			endcase
			quiet = (ph == 2);
			add_random(ph == 1 ? 200 : (ph == 2 ? 240 : 210));
			run_ticks();
		end

		$display("ran %0d ticks under %0d register settings, %0d mismatches, %0d left waiting",
			tracker.ticks_seen, settings_used, tracker.mismatches,
			tracker.expected_reports.size());
		$display("reports: none %0d single %0d double %0d triple %0d drag start %0d drag %0d",
			tracker.action_hist[0], tracker.action_hist[1], tracker.action_hist[2],
			tracker.action_hist[3], tracker.action_hist[4], tracker.action_hist[5]);
		if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
			$display("[mouse_multi_click_classifier] OK");
		end else begin
			$display("[mouse_multi_click_classifier] ERROR");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#2000000;
		$display("[mouse_multi_click_classifier] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
